>>> rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// Needs a clk and an arst_n signal in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define CHK_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("clocked check failed");

// Clocked check that also runs through reset
`define CHK_ANY(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("reset check failed");

`endif

>>> rtl/pwmss_pkg.sv
// Package for the PWM sliding window scanner: sizes, codes, request and
// result structs, cell control struct and score saturation. No dependencies.
`timescale 1ns / 1ps

package pwmss_pkg;

	// Sizing
	localparam int MAX_WIDTH     = 64;
	localparam int WEIGHT_BITS   = 24;
	localparam int POSITION_BITS = 32;
	localparam int ROWS          = 4;
	localparam int SCORE_BITS    = 32;
	localparam int WIDTH_BITS    = 7;
	localparam int CFG_BITS      = 32;
	localparam int IDX_BITS      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int SUM_BITS      = WEIGHT_BITS + IDX_BITS;
	localparam int WEFF_BITS     = ($clog2(MAX_WIDTH + 1) > WIDTH_BITS) ?
		$clog2(MAX_WIDTH + 1) : WIDTH_BITS;
	localparam int EXT_BITS      = ((SUM_BITS > SCORE_BITS) ? SUM_BITS : SCORE_BITS) + 1;

	// Codes
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_BASE = 1'b1
	} opcode_t;

	typedef enum logic [0:0] {
		REG_MOTIF_WIDTH = 1'b0,
		REG_MIN_SCORE   = 1'b1
	} cfg_reg_t;

	// Highest base code that carries a weight (T); anything above is "other"
	localparam logic [2:0] BASE_T     = 3'd3;
	localparam logic [2:0] BASE_OTHER = 3'd4;

	localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
	localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

	// Request item
	typedef struct packed {
		logic               opcode;
		logic [2:0]         base_code;
		logic               restart;
		logic [5:0]         weight_column;
		logic [1:0]         weight_row;
		logic signed [23:0] weight_value;
	} item_t;

	// Result item
	typedef struct packed {
		logic               window_full;
		logic               hit;
		logic [31:0]        match_start;
		logic signed [31:0] window_score;
	} result_t;

	// Broadcast to every cell of the chain
	typedef struct packed {
		logic                          shift;
		logic                          load;
		logic [1:0]                    row;
		logic [2:0]                    base;
		logic signed [WEIGHT_BITS-1:0] weight;
	} cell_ctrl_t;

	// Clamp a chain sum to the signed score range
	function automatic logic signed [SCORE_BITS-1:0] sat_score(
		input logic signed [SUM_BITS-1:0] s);
		logic signed [EXT_BITS-1:0] x;
		logic signed [EXT_BITS-1:0] hi;
		logic signed [EXT_BITS-1:0] lo;
		x  = EXT_BITS'(s);
		hi = EXT_BITS'(SCORE_MAX);
		lo = EXT_BITS'(SCORE_MIN);
		if (x > hi) begin
			return SCORE_MAX;
		end else if (x < lo) begin
			return SCORE_MIN;
		end
		return SCORE_BITS'(x);
	endfunction

endpackage

>>> rtl/pwmss_cell.sv
// One column cell of the scan chain: the column's four weights, one base of
// the history and the running sum of the window that reaches this column.
// Uses pwmss_pkg.
`timescale 1ns / 1ps

module pwmss_cell import pwmss_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cell_ctrl_t                 ctrl,
	input  logic                       sel,
	input  logic signed [SUM_BITS-1:0] psum_in,
	output logic signed [SUM_BITS-1:0] psum_out,
	input  logic [2:0]                 base_in,
	output logic [2:0]                 base_out
);

	logic signed [WEIGHT_BITS-1:0] wt_q [ROWS];
	logic signed [SUM_BITS-1:0]    psum_q;
	logic signed [SUM_BITS-1:0]    contrib;
	logic [2:0]                    base_q;

	// Weight load into this column
	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			wt_q[ctrl.row] <= ctrl.weight;
		end
	end

	// Other bases add nothing
	always_comb begin
		if (ctrl.base > BASE_T) begin
			contrib = '0;
		end else begin
			contrib = SUM_BITS'(wt_q[ctrl.base[1:0]]);
		end
	end

	// Sum moves one cell along per base
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			psum_q <= psum_in + contrib;
		end
	end

	// Base history moves one cell along with the sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_OTHER;
		end else if (ctrl.shift) begin
			base_q <= base_in;
		end
	end

	assign psum_out = psum_q;
	assign base_out = base_q;

endmodule

>>> rtl/pwm_sliding_window_scanner.sv
// Top level of the PWM sliding window scanner: request handshake, chain of
// column cells, position counter, score stage. Uses pwmss_pkg, pwmss_cell.
//
//   channel   signals                           width / type
//   item      item_valid, item_ready, item      item_t
//   result    result_valid, result_ready, result result_t
//   config    cfg_we, cfg_index, cfg_data       cfg_reg_t, 32 bits
//
// Base request: result goes through stage 1 and the output register; the
// score is read from cell w_eff-1 (motif_width clamped to 1..MAX_WIDTH).
// Load request: same result path, then item_ready stays low while the chain
// replays its base history against the new weights. Reset clears the
// position counter, replay, valids, min score; history to other, width 1.
// A stalled result holds its register; one more request enters the first
// stage, then item_ready drops until the result is taken.
`timescale 1ns / 1ps

module pwm_sliding_window_scanner import pwmss_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  item_t               item,
	output logic                result_valid,
	input  logic                result_ready,
	output result_t             result,
	input  logic                cfg_we,
	input  cfg_reg_t            cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	logic [WIDTH_BITS-1:0]        motif_width_q;
	logic signed [SCORE_BITS-1:0] min_score_q;
	logic [POSITION_BITS-1:0]     seen_q;
	logic [POSITION_BITS-1:0]     seen_base;
	logic [POSITION_BITS-1:0]     seen_new;
	logic [WEFF_BITS-1:0]         w_eff;
	logic [IDX_BITS-1:0]          w_idx;
	logic                         accept;
	logic                         is_base;
	logic                         out_free;
	logic                         full_new;
	logic [31:0]                  start_new;
	logic                         v_s1;
	logic                         full_s1;
	logic [31:0]                  start_s1;
	logic                         result_valid_q;
	result_t                      result_q;
	result_t                      res_next;
	logic signed [SCORE_BITS-1:0] score;
	cell_ctrl_t                   ctrl;
	logic signed [SUM_BITS-1:0]   psum [MAX_WIDTH];
	logic [2:0]                   hist [MAX_WIDTH];
	logic                         replay_q;
	logic [IDX_BITS-1:0]          replay_cnt_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motif_width_q <= WIDTH_BITS'(1);
			min_score_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MOTIF_WIDTH: motif_width_q <= cfg_data[WIDTH_BITS-1:0];
				REG_MIN_SCORE:   min_score_q   <= SCORE_BITS'(cfg_data);
			endcase
		end
	end

	// Window length clamped to 1..MAX_WIDTH
	always_comb begin
		if (motif_width_q == '0) begin
			w_eff = WEFF_BITS'(1);
		end else if (WEFF_BITS'(motif_width_q) > WEFF_BITS'(MAX_WIDTH)) begin
			w_eff = WEFF_BITS'(MAX_WIDTH);
		end else begin
			w_eff = WEFF_BITS'(motif_width_q);
		end
	end
	assign w_idx = IDX_BITS'(w_eff - WEFF_BITS'(1));

	// Handshake: first stage drains whenever the output slot frees
	assign out_free   = !result_valid_q || result_ready;
	assign item_ready = !replay_q && (!v_s1 || out_free);
	assign accept     = item_valid && item_ready;
	assign is_base    = (item.opcode == OP_BASE);

	// Position counter, restart starts again at the first base
	assign seen_base = item.restart ? '0 : seen_q;
	assign seen_new  = (&seen_base) ? seen_base : seen_base + POSITION_BITS'(1);
	assign full_new  = seen_new >= POSITION_BITS'(w_eff);
	assign start_new = 32'(seen_new - POSITION_BITS'(w_eff) + POSITION_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept && is_base) begin
			seen_q <= seen_new;
		end
	end

	// Replay after a load: the history rotates once round the chain, oldest
	// base first, so every running sum is rebuilt with the current weights
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replay_q     <= 1'b0;
			replay_cnt_q <= '0;
		end else if (replay_q) begin
			replay_cnt_q <= replay_cnt_q + IDX_BITS'(1);
			if (replay_cnt_q == IDX_BITS'(MAX_WIDTH - 1)) begin
				replay_q <= 1'b0;
			end
		end else if (accept && !is_base) begin
			replay_q     <= 1'b1;
			replay_cnt_q <= '0;
		end
	end

	// Broadcast to the chain
	always_comb begin
		ctrl.shift  = (accept && is_base) || replay_q;
		ctrl.load   = accept && !is_base;
		ctrl.row    = item.weight_row;
		ctrl.base   = replay_q ? hist[MAX_WIDTH-1] : item.base_code;
		ctrl.weight = WEIGHT_BITS'(item.weight_value);
	end

	// Chain of column cells
	for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_cell
		logic signed [SUM_BITS-1:0] chain_in;
		logic [2:0]                 base_link;
		logic                       col_sel;
		if (j == 0) begin : g_head
			assign chain_in  = '0;
			assign base_link = ctrl.base;
		end else begin : g_link
			assign chain_in  = psum[j-1];
			assign base_link = hist[j-1];
		end
		assign col_sel = (int'(item.weight_column) == j);
		pwmss_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sel      (col_sel),
			.psum_in  (chain_in),
			.psum_out (psum[j]),
			.base_in  (base_link),
			.base_out (hist[j])
		);
	end

	// Stage 1: request flags while the chain settles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || out_free) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			full_s1  <= is_base && full_new;
			start_s1 <= start_new;
		end
	end

	// Score stage: pick the window's cell, saturate, compare
	assign score = sat_score(psum[w_idx]);

	always_comb begin
		res_next = '0;
		if (full_s1) begin
			res_next.window_full  = 1'b1;
			res_next.hit          = (score >= min_score_q);
			res_next.match_start  = start_s1;
			res_next.window_score = score;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			result_q <= res_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> rtl/pwmss_checker.sv
// Port checker for the PWM sliding window scanner, bound to the top level.
// Uses pwmss_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pwmss_checker import pwmss_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	// A stalled result stays put
	`CHK_CLK(a_res_hold, result_valid && !result_ready |=> result_valid && $stable(result))

	// No result leaves right after reset
	`CHK_ANY(a_res_reset, $rose(arst_n) |-> !result_valid)

	// A hit only comes from a scored window
	`CHK_CLK(a_hit_full, result_valid && result.hit |-> result.window_full)

	// Loads and short windows carry all-zero fields
	`CHK_CLK(a_empty_zero, result_valid && !result.window_full |-> !result.hit && result.match_start == '0 && result.window_score == '0)

endmodule

bind pwm_sliding_window_scanner pwmss_checker u_pwmss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
